### rtl/touch_average_calibrate_events_top_macros.svh
// Assertion macros shared by the touch averaging and calibration RTL.
// Included by tacal_lane and the top level; no other dependencies.
`ifndef TOUCH_AVERAGE_CALIBRATE_EVENTS_TOP_MACROS_SVH
`define TOUCH_AVERAGE_CALIBRATE_EVENTS_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TACAL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TACAL_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tacal_pkg.sv
// Package for the touch averaging and calibration block: widths, codes,
// register indexes, lane state and lane control/status types. No dependencies.
package tacal_pkg;

    localparam int SAMPLES_PER_POINT_DEF = 10;
    localparam int COORD_W     = 12;
    localparam int SUM_W       = 16;
    localparam int CNT_W       = 4;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int DQ_W        = 2 * COORD_W;
    localparam int STEP_W      = $clog2(DQ_W + 1);
    localparam int MAP_STEPS   = DQ_W;
    localparam int RECIP_SHIFT = SUM_W + CNT_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [KIND_W-1:0] EV_DOWN   = 2'd0;
    localparam logic [KIND_W-1:0] EV_MOTION = 2'd1;
    localparam logic [KIND_W-1:0] EV_UP     = 2'd2;

    localparam logic [COORD_W-1:0] RAW_MIN_RST = 12'd0;
    localparam logic [COORD_W-1:0] RAW_MAX_RST = 12'hFFF;
    localparam logic [COORD_W-1:0] WIDTH_RST   = 12'd240;
    localparam logic [COORD_W-1:0] HEIGHT_RST  = 12'd320;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAW_MIN_X,
        REG_RAW_MAX_X,
        REG_RAW_MIN_Y,
        REG_RAW_MAX_Y,
        REG_CALIBRATING,
        REG_SCREEN_WIDTH,
        REG_SCREEN_HEIGHT
    } cfg_reg_t;

    typedef enum logic [2:0] {
        LANE_IDLE,
        LANE_AVG,
        LANE_SCALE,
        LANE_MAP,
        LANE_DONE
    } lane_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } lane_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lane_stat_t;

endpackage

### rtl/touch_average_calibrate_events_top.sv
// Touch sample averaging and calibration: one sample accepted per cycle while
// s_ready is high; a sample that closes a burst holds s_ready low while the X and
// Y lanes work through their steps: the burst average by reciprocal multiply, the
// span check and multiply, 24 restoring-division steps for the mapping (skipped in
// a lane that is calibrating or whose coordinate resolves without the division) and
// the hand-over of the result; a result still waiting on m_ready adds its stall.
// Uses tacal_pkg and tacal_lane.
`include "touch_average_calibrate_events_top_macros.svh"

module touch_average_calibrate_events_top
    import tacal_pkg::*;
#(
    parameter int SAMPLES_PER_POINT = SAMPLES_PER_POINT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [COORD_W-1:0]   s_raw_x,
    input  logic [COORD_W-1:0]   s_raw_y,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_event_kind,
    output logic [COORD_W-1:0]   m_pos_x,
    output logic [COORD_W-1:0]   m_pos_y,
    output logic                 m_clipped
);

    logic [COORD_W-1:0] raw_min_x_reg, raw_max_x_reg, raw_min_y_reg, raw_max_y_reg;
    logic [COORD_W-1:0] screen_width_reg, screen_height_reg;
    logic               calibrating_reg;

    logic               pressed_reg, pressed_next;
    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic [COORD_W-1:0] last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic               m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]  m_event_kind_reg, m_event_kind_next;
    logic [COORD_W-1:0] m_pos_x_reg, m_pos_x_next, m_pos_y_reg, m_pos_y_next;
    logic               m_clipped_reg, m_clipped_next;

    logic               accept;
    logic               burst_end;
    logic [SUM_W-1:0]   sum_x_add, sum_y_add;
    logic               lane_ack;
    lane_ctrl_t         lane_ctrl;
    lane_stat_t         stat_x, stat_y;
    logic [COORD_W-1:0] coord_x, coord_y;
    logic               clip_x, clip_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_min_x_reg     <= RAW_MIN_RST;
            raw_max_x_reg     <= RAW_MAX_RST;
            raw_min_y_reg     <= RAW_MIN_RST;
            raw_max_y_reg     <= RAW_MAX_RST;
            calibrating_reg   <= 1'b0;
            screen_width_reg  <= WIDTH_RST;
            screen_height_reg <= HEIGHT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RAW_MIN_X:     raw_min_x_reg     <= cfg_data;
                REG_RAW_MAX_X:     raw_max_x_reg     <= cfg_data;
                REG_RAW_MIN_Y:     raw_min_y_reg     <= cfg_data;
                REG_RAW_MAX_Y:     raw_max_y_reg     <= cfg_data;
                REG_CALIBRATING:   calibrating_reg   <= cfg_data[0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_ready   = !busy_reg && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign sum_x_add = sum_x_reg + {{(SUM_W - COORD_W){1'b0}}, s_raw_x};
    assign sum_y_add = sum_y_reg + {{(SUM_W - COORD_W){1'b0}}, s_raw_y};
    assign burst_end = ({1'b0, cnt_reg} + 1'b1) >= (CNT_W + 1)'(SAMPLES_PER_POINT);
    assign lane_ack  = stat_x.done && stat_y.done &&
                       (calibrating_reg || !m_valid_reg || m_ready);

    assign lane_ctrl.start = accept && !s_action && burst_end;
    assign lane_ctrl.ack   = lane_ack;

    tacal_lane #(
        .SAMPLES_PER_POINT(SAMPLES_PER_POINT)
    ) u_lane_x (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (lane_ctrl),
        .sum        (sum_x_add),
        .lo         (raw_min_x_reg),
        .hi         (raw_max_x_reg),
        .size       (screen_width_reg),
        .calibrating(calibrating_reg),
        .stat       (stat_x),
        .coord      (coord_x),
        .clip       (clip_x)
    );

    tacal_lane #(
        .SAMPLES_PER_POINT(SAMPLES_PER_POINT)
    ) u_lane_y (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (lane_ctrl),
        .sum        (sum_y_add),
        .lo         (raw_min_y_reg),
        .hi         (raw_max_y_reg),
        .size       (screen_height_reg),
        .calibrating(calibrating_reg),
        .stat       (stat_y),
        .coord      (coord_y),
        .clip       (clip_y)
    );

    always_comb begin
        pressed_next      = pressed_reg;
        busy_next         = busy_reg;
        cnt_next          = cnt_reg;
        sum_x_next        = sum_x_reg;
        sum_y_next        = sum_y_reg;
        last_x_next       = last_x_reg;
        last_y_next       = last_y_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_event_kind_next = m_event_kind_reg;
        m_pos_x_next      = m_pos_x_reg;
        m_pos_y_next      = m_pos_y_reg;
        m_clipped_next    = m_clipped_reg;
        if (accept) begin
            if (s_action) begin
                pressed_next      = 1'b0;
                cnt_next          = '0;
                sum_x_next        = '0;
                sum_y_next        = '0;
                m_valid_next      = 1'b1;
                m_event_kind_next = EV_UP;
                m_pos_x_next      = last_x_reg;
                m_pos_y_next      = last_y_reg;
                m_clipped_next    = 1'b0;
            end else if (burst_end) begin
                cnt_next   = '0;
                sum_x_next = '0;
                sum_y_next = '0;
                busy_next  = 1'b1;
            end else begin
                cnt_next   = cnt_reg + 1'b1;
                sum_x_next = sum_x_add;
                sum_y_next = sum_y_add;
            end
        end
        if (lane_ack) begin
            busy_next    = 1'b0;
            pressed_next = 1'b1;
            last_x_next  = coord_x;
            last_y_next  = coord_y;
            if (!calibrating_reg) begin
                m_valid_next      = 1'b1;
                m_event_kind_next = pressed_reg ? EV_MOTION : EV_DOWN;
                m_pos_x_next      = coord_x;
                m_pos_y_next      = coord_y;
                m_clipped_next    = clip_x || clip_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg <= 1'b0;
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pressed_reg <= pressed_next;
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            m_valid_reg <= m_valid_next;
        end
        m_event_kind_reg <= m_event_kind_next;
        m_pos_x_reg      <= m_pos_x_next;
        m_pos_y_reg      <= m_pos_y_next;
        m_clipped_reg    <= m_clipped_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = m_event_kind_reg;
    assign m_pos_x      = m_pos_x_reg;
    assign m_pos_y      = m_pos_y_reg;
    assign m_clipped    = m_clipped_reg;

    `TACAL_ASSERT_IMP(a_lanes_lockstep, aclk, aresetn, 1'b1, stat_x.busy == stat_y.busy, "lanes out of step")
    `TACAL_ASSERT_IMP(a_idle_lanes, aclk, aresetn, !busy_reg, !stat_x.busy, "lane active without a burst")
    `TACAL_ASSERT_IMP(a_busy_blocks_input, aclk, aresetn, busy_reg, !s_ready, "sample taken while lanes busy")
    `TACAL_ASSERT_IMP(a_pen_up_unclipped, aclk, aresetn, (m_valid_reg && m_event_kind_reg == EV_UP), !m_clipped_reg, "pen-up beat flagged clipped")

endmodule

### rtl/tacal_lane.sv
// One axis lane: burst average by reciprocal multiply, then, unless calibrating,
// linear mapping by registered multiply and restoring division. Uses tacal_pkg.
`include "touch_average_calibrate_events_top_macros.svh"

module tacal_lane
    import tacal_pkg::*;
#(
    parameter int SAMPLES_PER_POINT = SAMPLES_PER_POINT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lane_ctrl_t         ctrl,
    input  logic [SUM_W-1:0]   sum,
    input  logic [COORD_W-1:0] lo,
    input  logic [COORD_W-1:0] hi,
    input  logic [COORD_W-1:0] size,
    input  logic               calibrating,
    output lane_stat_t         stat,
    output logic [COORD_W-1:0] coord,
    output logic               clip
);

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + SAMPLES_PER_POINT - 1) / SAMPLES_PER_POINT);

    lane_state_t        state_reg, state_next;
    logic [DQ_W-1:0]    dq_reg, dq_next;
    logic [COORD_W-1:0] rem_reg, rem_next;
    logic [COORD_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [COORD_W-1:0] coord_reg, coord_next;
    logic               clip_reg, clip_next;

    logic [COORD_W:0]   trial;
    logic [COORD_W:0]   diff;
    logic               ge;
    logic [COORD_W-1:0] rem_step;
    logic [DQ_W-1:0]    dq_step;
    logic               last_map;

    logic [SUM_W+RECIP_W-1:0] avg_prod;
    logic [COORD_W-1:0] avg;
    logic               up, span_zero, beyond;
    logic [COORD_W-1:0] span, num;
    logic [DQ_W-1:0]    product;

    assign trial    = {rem_reg, dq_reg[DQ_W-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign ge       = trial >= {1'b0, div_reg};
    assign rem_step = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
    assign dq_step  = {dq_reg[DQ_W-2:0], ge};
    assign last_map = cnt_reg == STEP_W'(MAP_STEPS - 1);

    assign avg_prod  = {{RECIP_W{1'b0}}, dq_reg[SUM_W-1:0]} * {{SUM_W{1'b0}}, RECIP};
    assign avg       = dq_reg[COORD_W-1:0];
    assign up        = hi > lo;
    assign span_zero = hi == lo;
    assign span      = up ? (hi - lo) : (lo - hi);
    assign beyond    = up ? (avg < lo) : (avg > lo);
    assign num       = up ? (avg - lo) : (lo - avg);
    assign product   = num * size;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            LANE_IDLE:  if (ctrl.start) state_next = LANE_AVG;
            LANE_AVG:   state_next = LANE_SCALE;
            LANE_SCALE: begin
                if (calibrating || span_zero || beyond) begin
                    state_next = LANE_DONE;
                end else begin
                    state_next = LANE_MAP;
                end
            end
            LANE_MAP:   if (last_map) state_next = LANE_DONE;
            LANE_DONE:  if (ctrl.ack) state_next = LANE_IDLE;
            default:    state_next = LANE_IDLE;
        endcase
    end

    always_comb begin
        stat.busy = state_reg != LANE_IDLE;
        stat.done = state_reg == LANE_DONE;
    end

    always_comb begin
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        coord_next = coord_reg;
        clip_next  = clip_reg;
        unique case (state_reg)
            LANE_IDLE: begin
                if (ctrl.start) begin
                    dq_next = {{(DQ_W - SUM_W){1'b0}}, sum};
                end
            end
            LANE_AVG: begin
                dq_next = {{(DQ_W - COORD_W){1'b0}}, avg_prod[RECIP_SHIFT +: COORD_W]};
            end
            LANE_SCALE: begin
                if (calibrating) begin
                    coord_next = avg;
                    clip_next  = 1'b0;
                end else if (span_zero || beyond) begin
                    coord_next = '0;
                    clip_next  = 1'b1;
                end else begin
                    dq_next  = product;
                    rem_next = '0;
                    div_next = span;
                    cnt_next = '0;
                end
            end
            LANE_MAP: begin
                dq_next  = dq_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (last_map) begin
                    if (dq_step > {{(DQ_W - COORD_W){1'b0}}, size}) begin
                        coord_next = size;
                        clip_next  = 1'b1;
                    end else begin
                        coord_next = dq_step[COORD_W-1:0];
                        clip_next  = 1'b0;
                    end
                end
            end
            LANE_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LANE_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        coord_reg <= coord_next;
        clip_reg  <= clip_next;
    end

    assign coord = coord_reg;
    assign clip  = clip_reg;

    `TACAL_ASSERT_IMP(a_rem_below_div, aclk, aresetn, (state_reg == LANE_MAP), rem_reg < div_reg, "remainder not below divisor")
    `TACAL_ASSERT_NXT(a_done_holds, aclk, aresetn, (state_reg == LANE_DONE && !ctrl.ack), state_reg == LANE_DONE, "lane result dropped before ack")
    `TACAL_ASSERT_IMP(a_coord_in_screen, aclk, aresetn, (stat.done && !calibrating), coord_reg <= size, "mapped coordinate beyond screen size")

endmodule
